// ===== rtl/qmr_pkg.sv =====
package qmr_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FRAC_DEF  = 24;
  localparam int NCOMP     = 4;
  localparam int NTERM     = 4;
  localparam int NOPND     = 8;
  localparam int NACT      = 5;

  // highest defined action code; codes above it give an all-zero word
  localparam logic [2:0] ACT_ROT_Z = 3'd4;

  typedef enum logic [2:0] {
    OP_AW, OP_AX, OP_AY, OP_AZ, OP_BW, OP_BX, OP_BY, OP_BZ
  } opnd_t;

  typedef enum logic [1:0] {
    TS_ZERO, TS_POS, TS_NEG
  } term_sign_t;

  typedef struct packed {
    term_sign_t s;
    opnd_t      l;
    opnd_t      r;
  } term_t;

  localparam term_t TZ = '{TS_ZERO, OP_AW, OP_BW};

  // per action, per component, the four signed operand products
  localparam term_t TERMS [NACT][NCOMP][NTERM] = '{
    '{ '{ '{TS_POS, OP_AW, OP_BW}, '{TS_NEG, OP_AX, OP_BX},
          '{TS_NEG, OP_AY, OP_BY}, '{TS_NEG, OP_AZ, OP_BZ} },
       '{ '{TS_POS, OP_AW, OP_BX}, '{TS_POS, OP_AX, OP_BW},
          '{TS_POS, OP_AY, OP_BZ}, '{TS_NEG, OP_AZ, OP_BY} },
       '{ '{TS_POS, OP_AW, OP_BY}, '{TS_NEG, OP_AX, OP_BZ},
          '{TS_POS, OP_AY, OP_BW}, '{TS_POS, OP_AZ, OP_BX} },
       '{ '{TS_POS, OP_AW, OP_BZ}, '{TS_POS, OP_AX, OP_BY},
          '{TS_NEG, OP_AY, OP_BX}, '{TS_POS, OP_AZ, OP_BW} } },
    '{ '{ '{TS_NEG, OP_AX, OP_BX}, '{TS_NEG, OP_AY, OP_BY},
          '{TS_NEG, OP_AZ, OP_BZ}, TZ },
       '{ '{TS_POS, OP_AW, OP_BX}, '{TS_POS, OP_AY, OP_BZ},
          '{TS_NEG, OP_AZ, OP_BY}, TZ },
       '{ '{TS_POS, OP_AW, OP_BY}, '{TS_NEG, OP_AX, OP_BZ},
          '{TS_POS, OP_AZ, OP_BX}, TZ },
       '{ '{TS_POS, OP_AW, OP_BZ}, '{TS_POS, OP_AX, OP_BY},
          '{TS_NEG, OP_AY, OP_BX}, TZ } },
    '{ '{ TZ, TZ, TZ, TZ },
       '{ '{TS_POS, OP_AX, OP_AX}, '{TS_POS, OP_AW, OP_AW},
          '{TS_NEG, OP_AZ, OP_AZ}, '{TS_NEG, OP_AY, OP_AY} },
       '{ '{TS_POS, OP_AX, OP_AY}, '{TS_POS, OP_AW, OP_AZ},
          '{TS_POS, OP_AZ, OP_AW}, '{TS_POS, OP_AY, OP_AX} },
       '{ '{TS_POS, OP_AX, OP_AZ}, '{TS_NEG, OP_AW, OP_AY},
          '{TS_POS, OP_AZ, OP_AX}, '{TS_NEG, OP_AY, OP_AW} } },
    '{ '{ TZ, TZ, TZ, TZ },
       '{ '{TS_POS, OP_AY, OP_AX}, '{TS_NEG, OP_AZ, OP_AW},
          '{TS_NEG, OP_AW, OP_AZ}, '{TS_POS, OP_AX, OP_AY} },
       '{ '{TS_POS, OP_AY, OP_AY}, '{TS_NEG, OP_AZ, OP_AZ},
          '{TS_POS, OP_AW, OP_AW}, '{TS_NEG, OP_AX, OP_AX} },
       '{ '{TS_POS, OP_AY, OP_AZ}, '{TS_POS, OP_AZ, OP_AY},
          '{TS_POS, OP_AW, OP_AX}, '{TS_POS, OP_AX, OP_AW} } },
    '{ '{ TZ, TZ, TZ, TZ },
       '{ '{TS_POS, OP_AZ, OP_AX}, '{TS_POS, OP_AY, OP_AW},
          '{TS_POS, OP_AX, OP_AZ}, '{TS_POS, OP_AW, OP_AY} },
       '{ '{TS_POS, OP_AZ, OP_AY}, '{TS_POS, OP_AY, OP_AZ},
          '{TS_NEG, OP_AX, OP_AW}, '{TS_NEG, OP_AW, OP_AX} },
       '{ '{TS_POS, OP_AZ, OP_AZ}, '{TS_NEG, OP_AY, OP_AY},
          '{TS_NEG, OP_AX, OP_AX}, '{TS_POS, OP_AW, OP_AW} } }
  };

endpackage

// ===== rtl/qmr_select.sv =====
module qmr_select #(
  parameter int WIDTH = qmr_pkg::WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    in_valid,
  input  logic [2:0]              action,
  input  logic signed [WIDTH-1:0] opnd [qmr_pkg::NOPND],
  output logic                    valid,
  output logic signed [WIDTH-1:0] lhs  [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  output logic signed [WIDTH-1:0] rhs  [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  output logic                    neg  [qmr_pkg::NCOMP][qmr_pkg::NTERM]
);
  import qmr_pkg::*;

  logic signed [WIDTH-1:0] lhs_next [NCOMP][NTERM];
  logic signed [WIDTH-1:0] rhs_next [NCOMP][NTERM];
  logic                    neg_next [NCOMP][NTERM];

  always_comb begin
    term_t tm;
    tm = TZ;
    for (int c = 0; c < NCOMP; c++) begin
      for (int t = 0; t < NTERM; t++) begin
        tm = (action <= ACT_ROT_Z) ? TERMS[action][c][t] : TZ;
        // a missing term multiplies zero by zero
        if (tm.s == TS_ZERO) begin
          lhs_next[c][t] = '0;
          rhs_next[c][t] = '0;
        end else begin
          lhs_next[c][t] = opnd[tm.l];
          rhs_next[c][t] = opnd[tm.r];
        end
        neg_next[c][t] = (tm.s == TS_NEG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lhs <= lhs_next;
      rhs <= rhs_next;
      neg <= neg_next;
    end
  end

endmodule

// ===== rtl/qmr_mul.sv =====
module qmr_mul #(
  parameter int WIDTH     = qmr_pkg::WIDTH_DEF,
  parameter int FRAC_BITS = qmr_pkg::FRAC_DEF,
  localparam int PW = 2 * WIDTH,
  localparam int TW = (PW - FRAC_BITS > WIDTH) ? PW - FRAC_BITS : WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_pp,
  input  logic                    load_prod,
  input  logic                    in_valid,
  input  logic signed [WIDTH-1:0] lhs  [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  input  logic signed [WIDTH-1:0] rhs  [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  input  logic                    neg  [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  output logic                    pp_valid,
  output logic                    valid,
  output logic signed [TW-1:0]    term [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  output logic                    term_neg [qmr_pkg::NCOMP][qmr_pkg::NTERM]
);
  import qmr_pkg::*;

  // operands split into an unsigned low half and a signed high half
  localparam int LH = WIDTH / 2;
  localparam int HH = WIDTH - LH;
  localparam int LLW = 2 * LH + 2;
  localparam int MXW = LH + HH + 1;
  localparam int HHW = 2 * HH;

  logic signed [2*LH+1:0]  pp_ll [NCOMP][NTERM];
  logic signed [LH+HH:0]   pp_lh [NCOMP][NTERM];
  logic signed [LH+HH:0]   pp_hl [NCOMP][NTERM];
  logic signed [2*HH-1:0]  pp_hh [NCOMP][NTERM];
  logic                    pp_neg [NCOMP][NTERM];
  logic signed [TW-1:0]    term_next [NCOMP][NTERM];

  logic signed [2*LH+1:0]  ll_next [NCOMP][NTERM];
  logic signed [LH+HH:0]   lh_next [NCOMP][NTERM];
  logic signed [LH+HH:0]   hl_next [NCOMP][NTERM];
  logic signed [2*HH-1:0]  hh_next [NCOMP][NTERM];

  always_comb begin
    logic signed [LH:0]   al, bl;
    logic signed [HH-1:0] ah, bh;
    al = '0; bl = '0; ah = '0; bh = '0;
    for (int c = 0; c < NCOMP; c++) begin
      for (int t = 0; t < NTERM; t++) begin
        al = {1'b0, lhs[c][t][LH-1:0]};
        bl = {1'b0, rhs[c][t][LH-1:0]};
        ah = lhs[c][t][WIDTH-1:LH];
        bh = rhs[c][t][WIDTH-1:LH];
        ll_next[c][t] = LLW'(al) * LLW'(bl);
        lh_next[c][t] = MXW'(al) * MXW'(bh);
        hl_next[c][t] = MXW'(ah) * MXW'(bl);
        hh_next[c][t] = HHW'(ah) * HHW'(bh);
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] prod;
    prod = '0;
    for (int c = 0; c < NCOMP; c++) begin
      for (int t = 0; t < NTERM; t++) begin
        prod = (PW'(pp_hh[c][t]) <<< (2 * LH))
             + ((PW'(pp_lh[c][t]) + PW'(pp_hl[c][t])) <<< LH)
             + PW'(pp_ll[c][t]);
        // truncate toward minus infinity
        term_next[c][t] = TW'(prod >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      if (load_pp) begin
        pp_valid <= in_valid;
      end
      if (load_prod) begin
        valid <= pp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pp) begin
      pp_ll  <= ll_next;
      pp_lh  <= lh_next;
      pp_hl  <= hl_next;
      pp_hh  <= hh_next;
      pp_neg <= neg;
    end
    if (load_prod) begin
      term     <= term_next;
      term_neg <= pp_neg;
    end
  end

endmodule

// ===== rtl/qmr_acc.sv =====
module qmr_acc #(
  parameter int WIDTH     = qmr_pkg::WIDTH_DEF,
  parameter int FRAC_BITS = qmr_pkg::FRAC_DEF,
  localparam int TW = (2 * WIDTH - FRAC_BITS > WIDTH) ? 2 * WIDTH - FRAC_BITS : WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_pair,
  input  logic                    load_out,
  input  logic                    in_valid,
  input  logic signed [TW-1:0]    term     [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  input  logic                    term_neg [qmr_pkg::NCOMP][qmr_pkg::NTERM],
  output logic                    pair_valid,
  output logic                    valid,
  output logic signed [WIDTH-1:0] res [qmr_pkg::NCOMP],
  output logic                    overflow
);
  import qmr_pkg::*;

  localparam int EW = TW + 1;
  localparam int PSW = TW + 2;
  localparam int SW = TW + 3;

  logic signed [PSW-1:0]   pair      [NCOMP][2];
  logic signed [PSW-1:0]   pair_next [NCOMP][2];
  logic signed [WIDTH-1:0] res_next  [NCOMP];
  logic                    overflow_next;

  always_comb begin
    logic signed [EW-1:0] e [NTERM];
    for (int t = 0; t < NTERM; t++) begin
      e[t] = '0;
    end
    for (int c = 0; c < NCOMP; c++) begin
      for (int t = 0; t < NTERM; t++) begin
        e[t] = term_neg[c][t] ? -EW'(term[c][t]) : EW'(term[c][t]);
      end
      pair_next[c][0] = PSW'(e[0]) + PSW'(e[1]);
      pair_next[c][1] = PSW'(e[2]) + PSW'(e[3]);
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    s = '0;
    overflow_next = 1'b0;
    for (int c = 0; c < NCOMP; c++) begin
      s = SW'(pair[c][0]) + SW'(pair[c][1]);
      // in range only when all bits above the sign bit agree with it
      if ((&s[SW-1:WIDTH-1]) || !(|s[SW-1:WIDTH-1])) begin
        res_next[c] = s[WIDTH-1:0];
      end else begin
        res_next[c]   = s[SW-1] ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
        overflow_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      if (load_pair) begin
        pair_valid <= in_valid;
      end
      if (load_out) begin
        valid <= pair_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pair) begin
      pair <= pair_next;
    end
    if (load_out) begin
      res      <= res_next;
      overflow <= overflow_next;
    end
  end

endmodule

// ===== rtl/quaternion_multiply_rotate_unit.sv =====
// Quaternion multiply / rotate unit, signed fixed point (default Q8.24).
// Input channel: in_valid/in_stall carry one word of action, a_w..a_z and
// b_w..b_z. Output channel: out_valid/out_stall carry r_w..r_z and
// overflow. A word moves at a rising edge where valid is high and stall low.
// Actions: 0 Hamilton product a*b, 1 a times vector (b_x,b_y,b_z), 2/3/4 the
// x/y/z axis rotated by a (r_w is 0). Codes 5 to 7 give an all-zero word.
// Each component sums four truncated products and saturates; overflow is
// set when any component saturated.
// Five register stages: operand select, partial products, product assembly
// and shift, pair sums, final sum and saturation into the output register.
// out_valid rises once the word has passed the select, partial product,
// product, pair and output registers. One word enters per cycle while in_stall
// is low; every stage takes a new word each cycle it is not held.
// When out_stall is held, the output register holds its word and the stages
// behind it fill up; empty stages keep advancing, so in_stall rises only
// once every stage holds a word. No word is dropped or repeated.
// Synchronous reset empties all stages; no word is delivered before a new
// one is accepted.
module quaternion_multiply_rotate_unit #(
  parameter int WIDTH     = qmr_pkg::WIDTH_DEF,
  parameter int FRAC_BITS = qmr_pkg::FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              action,
  input  logic signed [WIDTH-1:0] a_w,
  input  logic signed [WIDTH-1:0] a_x,
  input  logic signed [WIDTH-1:0] a_y,
  input  logic signed [WIDTH-1:0] a_z,
  input  logic signed [WIDTH-1:0] b_w,
  input  logic signed [WIDTH-1:0] b_x,
  input  logic signed [WIDTH-1:0] b_y,
  input  logic signed [WIDTH-1:0] b_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] r_w,
  output logic signed [WIDTH-1:0] r_x,
  output logic signed [WIDTH-1:0] r_y,
  output logic signed [WIDTH-1:0] r_z,
  output logic                    overflow
);
  import qmr_pkg::*;

  localparam int TW = (2 * WIDTH - FRAC_BITS > WIDTH) ? 2 * WIDTH - FRAC_BITS : WIDTH;

  logic signed [WIDTH-1:0] opnd [NOPND];
  logic signed [WIDTH-1:0] lhs  [NCOMP][NTERM];
  logic signed [WIDTH-1:0] rhs  [NCOMP][NTERM];
  logic                    neg  [NCOMP][NTERM];
  logic signed [TW-1:0]    term [NCOMP][NTERM];
  logic                    term_neg [NCOMP][NTERM];
  logic signed [WIDTH-1:0] res  [NCOMP];

  logic sel_valid, pp_valid, prod_valid, pair_valid;
  logic load_sel, load_pp, load_prod, load_pair, load_out;

  // a stage loads when it is empty or its word moves on
  assign load_out  = !out_valid || !out_stall;
  assign load_pair = !pair_valid || load_out;
  assign load_prod = !prod_valid || load_pair;
  assign load_pp   = !pp_valid || load_prod;
  assign load_sel  = !sel_valid || load_pp;
  assign in_stall  = !load_sel;

  assign opnd[OP_AW] = a_w;
  assign opnd[OP_AX] = a_x;
  assign opnd[OP_AY] = a_y;
  assign opnd[OP_AZ] = a_z;
  assign opnd[OP_BW] = b_w;
  assign opnd[OP_BX] = b_x;
  assign opnd[OP_BY] = b_y;
  assign opnd[OP_BZ] = b_z;

  qmr_select #(
    .WIDTH(WIDTH)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .load     (load_sel),
    .in_valid (in_valid),
    .action   (action),
    .opnd     (opnd),
    .valid    (sel_valid),
    .lhs      (lhs),
    .rhs      (rhs),
    .neg      (neg)
  );

  qmr_mul #(
    .WIDTH     (WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .load_pp   (load_pp),
    .load_prod (load_prod),
    .in_valid  (sel_valid),
    .lhs       (lhs),
    .rhs       (rhs),
    .neg       (neg),
    .pp_valid  (pp_valid),
    .valid     (prod_valid),
    .term      (term),
    .term_neg  (term_neg)
  );

  qmr_acc #(
    .WIDTH     (WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_acc (
    .clk        (clk),
    .rst        (rst),
    .load_pair  (load_pair),
    .load_out   (load_out),
    .in_valid   (prod_valid),
    .term       (term),
    .term_neg   (term_neg),
    .pair_valid (pair_valid),
    .valid      (out_valid),
    .res        (res),
    .overflow   (overflow)
  );

  assign r_w = res[0];
  assign r_x = res[1];
  assign r_y = res[2];
  assign r_z = res[3];

endmodule
